@@ sv/gpu_integer_alu_with_carry_defines.svh @@
// assertion macros for the integer alu with carry
`ifndef GPU_INTEGER_ALU_WITH_CARRY_DEFINES_SVH
`define GPU_INTEGER_ALU_WITH_CARRY_DEFINES_SVH

// same-cycle implication, checked outside reset
`define GIA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define GIA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/gia_pkg.sv @@
// shared types and constants for the integer alu with carry
`timescale 1ns / 1ps

package gia_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned WIDE_W  = 64;
	localparam int unsigned FUNC_W  = 4;
	localparam int unsigned SHAMT_W = 5;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned NIB_W   = 4;
	localparam int unsigned LANES   = WORD_W / BYTE_W;

	typedef enum logic [FUNC_W-1:0] {
		FN_MULWIDE     = 4'd0,
		FN_MADWIDE_CC  = 4'd1,
		FN_MADWIDEC    = 4'd2,
		FN_ADD_CC      = 4'd3,
		FN_ADDC_CC     = 4'd4,
		FN_ADDC        = 4'd5,
		FN_SUB_CC      = 4'd6,
		FN_SUBC_CC     = 4'd7,
		FN_SUBC        = 4'd8,
		FN_FUNNELSHIFT = 4'd9,
		FN_PERMUTE     = 4'd10
	} func_t;

	typedef struct packed {
		logic [WIDE_W-1:0] result;
		logic              carry_new;
		logic              carry_we;
	} exec_t;

endpackage

@@ sv/gia_if.sv @@
// request and response channel interfaces
`timescale 1ns / 1ps

interface gia_req_if;
	logic                          valid;
	logic                          ready;
	logic [gia_pkg::FUNC_W-1:0]    func;
	logic [gia_pkg::WORD_W-1:0]    operand_a;
	logic [gia_pkg::WORD_W-1:0]    operand_b;
	logic [gia_pkg::WIDE_W-1:0]    operand_c;

	modport source (output valid, output func, output operand_a, output operand_b,
		output operand_c, input ready);
	modport sink (input valid, input func, input operand_a, input operand_b,
		input operand_c, output ready);
endinterface

interface gia_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [gia_pkg::WIDE_W-1:0]    result;
	logic                          carry_out;

	modport source (output valid, output result, output carry_out, input ready);
	modport sink (input valid, input result, input carry_out, output ready);
endinterface

@@ sv/gia_permute.sv @@
// byte permute of b:a with sign replication
`timescale 1ns / 1ps

module gia_permute (
	input  logic [gia_pkg::WORD_W-1:0]          lo,
	input  logic [gia_pkg::WORD_W-1:0]          hi,
	input  logic [gia_pkg::LANES*gia_pkg::NIB_W-1:0] sel,
	output logic [gia_pkg::WORD_W-1:0]          result
);

	logic [2*gia_pkg::WORD_W-1:0] src;

	assign src = {hi, lo};

	always_comb begin
		logic [gia_pkg::NIB_W-1:0]  nib;
		logic [gia_pkg::BYTE_W-1:0] pick;
		result = '0;
		for (int k = 0; k < gia_pkg::LANES; k++) begin
			nib  = sel[k*gia_pkg::NIB_W +: gia_pkg::NIB_W];
			pick = src[nib[gia_pkg::NIB_W-2:0]*gia_pkg::BYTE_W +: gia_pkg::BYTE_W];
			if (nib[gia_pkg::NIB_W-1]) begin
				result[k*gia_pkg::BYTE_W +: gia_pkg::BYTE_W] =
					{gia_pkg::BYTE_W{pick[gia_pkg::BYTE_W-1]}};
			end else begin
				result[k*gia_pkg::BYTE_W +: gia_pkg::BYTE_W] = pick;
			end
		end
	end

endmodule

@@ sv/gia_exec.sv @@
// single-pass execute logic: multiply, add/sub with carry, funnel shift, permute
`timescale 1ns / 1ps

module gia_exec (
	input  logic [gia_pkg::FUNC_W-1:0] func,
	input  logic [gia_pkg::WORD_W-1:0] operand_a,
	input  logic [gia_pkg::WORD_W-1:0] operand_b,
	input  logic [gia_pkg::WIDE_W-1:0] operand_c,
	input  logic                       carry_in,
	output gia_pkg::exec_t             ex
);

	gia_pkg::func_t                op;
	logic [gia_pkg::WIDE_W-1:0]    prod;
	logic                          mad_cin;
	logic [gia_pkg::WIDE_W:0]      mad_sum;
	logic                          is_sub;
	logic                          add_cin;
	logic [gia_pkg::WORD_W-1:0]    b_sel;
	logic [gia_pkg::WORD_W:0]      add_sum;
	logic [gia_pkg::SHAMT_W-1:0]   shamt;
	logic [2*gia_pkg::WORD_W-1:0]  shifted;
	logic [gia_pkg::WORD_W-1:0]    perm;

	assign op = gia_pkg::func_t'(func);

	assign prod    = {{gia_pkg::WORD_W{1'b0}}, operand_a} * {{gia_pkg::WORD_W{1'b0}}, operand_b};
	assign mad_cin = (op == gia_pkg::FN_MADWIDEC) ? carry_in : 1'b0;
	assign mad_sum = {1'b0, prod} + {1'b0, operand_c} + {{gia_pkg::WIDE_W{1'b0}}, mad_cin};

	// flag means no borrow for subtraction
	assign is_sub = (op == gia_pkg::FN_SUB_CC) || (op == gia_pkg::FN_SUBC_CC) ||
		(op == gia_pkg::FN_SUBC);
	assign b_sel  = is_sub ? ~operand_b : operand_b;

	always_comb begin
		case (op)
			gia_pkg::FN_ADD_CC: add_cin = 1'b0;
			gia_pkg::FN_SUB_CC: add_cin = 1'b1;
			default:            add_cin = carry_in;
		endcase
	end

	assign add_sum = {1'b0, operand_a} + {1'b0, b_sel} + {{gia_pkg::WORD_W{1'b0}}, add_cin};

	assign shamt   = operand_c[gia_pkg::SHAMT_W-1:0];
	assign shifted = {operand_b, operand_a} << shamt;

	gia_permute u_permute (
		.lo     (operand_a),
		.hi     (operand_b),
		.sel    (operand_c[gia_pkg::LANES*gia_pkg::NIB_W-1:0]),
		.result (perm)
	);

	always_comb begin
		ex.result    = '0;
		ex.carry_new = add_sum[gia_pkg::WORD_W];
		ex.carry_we  = 1'b0;
		case (op)
			gia_pkg::FN_MULWIDE: begin
				ex.result = prod;
			end
			gia_pkg::FN_MADWIDE_CC: begin
				ex.result    = mad_sum[gia_pkg::WIDE_W-1:0];
				ex.carry_new = mad_sum[gia_pkg::WIDE_W];
				ex.carry_we  = 1'b1;
			end
			gia_pkg::FN_MADWIDEC: begin
				ex.result = mad_sum[gia_pkg::WIDE_W-1:0];
			end
			gia_pkg::FN_ADD_CC, gia_pkg::FN_ADDC_CC,
			gia_pkg::FN_SUB_CC, gia_pkg::FN_SUBC_CC: begin
				ex.result   = {{gia_pkg::WORD_W{1'b0}}, add_sum[gia_pkg::WORD_W-1:0]};
				ex.carry_we = 1'b1;
			end
			gia_pkg::FN_ADDC, gia_pkg::FN_SUBC: begin
				ex.result = {{gia_pkg::WORD_W{1'b0}}, add_sum[gia_pkg::WORD_W-1:0]};
			end
			gia_pkg::FN_FUNNELSHIFT: begin
				ex.result = {{gia_pkg::WORD_W{1'b0}},
					shifted[2*gia_pkg::WORD_W-1:gia_pkg::WORD_W]};
			end
			gia_pkg::FN_PERMUTE: begin
				ex.result = {{gia_pkg::WORD_W{1'b0}}, perm};
			end
			default: begin
				ex.result = '0;
			end
		endcase
	end

endmodule

@@ sv/gpu_integer_alu_with_carry.sv @@
// Integer ALU with a stored carry flag.
// Requests arrive on req (func, operand_a, operand_b, operand_c) and are taken
// at a clock edge where req.valid and req.ready are both high. Each request
// gives exactly one response on rsp (result, carry_out), in request order.
// The request goes into an input register; the execute logic (32x32 multiply
// with 64-bit add, 32-bit add/sub with carry, funnel shift, byte permute)
// sits between that register and the response register.
// The request passes the input register and then the response register before
// rsp.valid rises. Throughput: one request per cycle while rsp.ready is high;
// the carry flag is written as a request leaves the input register, so the
// next request sees it at once. carry_out is the flag after the operation;
// only the _cc opcodes change it, unused opcodes return zero and keep it.
// When rsp.ready is low the response register holds, the input register
// fills behind it and then req.ready drops; nothing is lost or duplicated.
// Reset clears both stage valids and the carry flag to zero.
`timescale 1ns / 1ps
`include "gpu_integer_alu_with_carry_defines.svh"

module gpu_integer_alu_with_carry (
	input  logic     clk,
	input  logic     arst_n,
	gia_req_if.sink  req,
	gia_rsp_if.source rsp
);

	logic                          valid_s1;
	logic [gia_pkg::FUNC_W-1:0]    func_s1;
	logic [gia_pkg::WORD_W-1:0]    a_s1;
	logic [gia_pkg::WORD_W-1:0]    b_s1;
	logic [gia_pkg::WIDE_W-1:0]    c_s1;
	logic                          valid_s2;
	logic [gia_pkg::WIDE_W-1:0]    result_s2;
	logic                          carry_s2;
	logic                          carry_q;
	logic                          adv;
	logic                          take;
	logic                          carry_after;
	gia_pkg::exec_t                ex;

	assign adv       = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || adv;
	assign take      = req.valid && req.ready;

	gia_exec u_exec (
		.func      (func_s1),
		.operand_a (a_s1),
		.operand_b (b_s1),
		.operand_c (c_s1),
		.carry_in  (carry_q),
		.ex        (ex)
	);

	assign carry_after = ex.carry_we ? ex.carry_new : carry_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			carry_q  <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
				carry_q  <= carry_after;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (take) begin
			func_s1 <= req.func;
			a_s1    <= req.operand_a;
			b_s1    <= req.operand_b;
			c_s1    <= req.operand_c;
		end
		if (adv) begin
			result_s2 <= ex.result;
			carry_s2  <= carry_after;
		end
	end

	assign rsp.valid     = valid_s2;
	assign rsp.result    = result_s2;
	assign rsp.carry_out = carry_s2;

	`GIA_ASSERT_NEXT(a_flag_hold, clk, arst_n, !adv, $stable(carry_q), "carry flag moved without an advance")
	`GIA_ASSERT_NOW(a_flag_match, clk, arst_n, valid_s2, carry_s2 == carry_q, "response carry differs from flag")
	`GIA_ASSERT_NEXT(a_s1_fill, clk, arst_n, take, valid_s1, "taken request missing from input register")

endmodule

@@ sim/gpu_integer_alu_with_carry_tb.sv @@
// self-checking testbench for the integer alu with carry
`timescale 1ns / 1ps

module gpu_integer_alu_with_carry_tb;

	localparam logic [gia_pkg::FUNC_W-1:0] FN_UNUSED_LO = 4'd11;
	localparam logic [gia_pkg::FUNC_W-1:0] FN_UNUSED_HI = 4'd15;
	localparam int unsigned LONG_HOLD = 300;

	typedef struct {
		logic [gia_pkg::FUNC_W-1:0] func;
		logic [gia_pkg::WORD_W-1:0] a;
		logic [gia_pkg::WORD_W-1:0] b;
		logic [gia_pkg::WIDE_W-1:0] c;
	} alu_req_t;

	typedef struct {
		logic [gia_pkg::WIDE_W-1:0] result;
		logic                       carry_out;
	} alu_rsp_t;

	logic clk = 1'b0;
	logic arst_n;

	gia_req_if req_ch();
	gia_rsp_if rsp_ch();

	gpu_integer_alu_with_carry uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #1 clk = ~clk;

	alu_req_t    pending_ops[$];
	alu_rsp_t    expected_rsps[$];
	alu_req_t    next_op;
	alu_req_t    seen_op;
	alu_rsp_t    want;
	logic        carry_model;
	int          err_cnt = 0;
	int unsigned send_idle_pct = 0;
	int unsigned rsp_stall_pct = 0;
	bit          long_hold = 1'b0;
	int unsigned hold_cnt;

	function automatic logic [gia_pkg::WORD_W-1:0] permute_bytes(
		input logic [gia_pkg::WORD_W-1:0] lo, input logic [gia_pkg::WORD_W-1:0] hi,
		input logic [15:0] sel);
		logic [2*gia_pkg::WORD_W-1:0] src;
		logic [gia_pkg::BYTE_W-1:0]   lane;
		logic [gia_pkg::NIB_W-1:0]    nib;
		logic [gia_pkg::WORD_W-1:0]   res;
		src = {hi, lo};
		res = '0;
		for (int k = 0; k < gia_pkg::LANES; k++) begin
			nib = sel[k*gia_pkg::NIB_W +: gia_pkg::NIB_W];
			lane = src[nib[2:0]*gia_pkg::BYTE_W +: gia_pkg::BYTE_W];
			if (nib[3])
				lane = {gia_pkg::BYTE_W{lane[gia_pkg::BYTE_W-1]}};
			res[k*gia_pkg::BYTE_W +: gia_pkg::BYTE_W] = lane;
		end
		return res;
	endfunction

	// advances carry_model as the block's flag
	function alu_rsp_t compute_alu_op(input alu_req_t r);
		alu_rsp_t                     o;
		logic [gia_pkg::WIDE_W-1:0]   prod;
		logic [gia_pkg::WIDE_W:0]     wide_sum;
		logic [gia_pkg::WORD_W:0]     sum;
		logic [2*gia_pkg::WORD_W-1:0] shifted;
		prod = {{gia_pkg::WORD_W{1'b0}}, r.a} * {{gia_pkg::WORD_W{1'b0}}, r.b};
		o.result = '0;
		case (r.func)
			gia_pkg::FN_MULWIDE: o.result = prod;
			gia_pkg::FN_MADWIDE_CC: begin
				wide_sum = {1'b0, prod} + {1'b0, r.c};
				o.result = wide_sum[gia_pkg::WIDE_W-1:0];
				carry_model = wide_sum[gia_pkg::WIDE_W];
			end
			gia_pkg::FN_MADWIDEC: o.result = prod + r.c +
				{{(gia_pkg::WIDE_W-1){1'b0}}, carry_model};
			gia_pkg::FN_ADD_CC, gia_pkg::FN_ADDC_CC, gia_pkg::FN_ADDC: begin
				sum = {1'b0, r.a} + {1'b0, r.b} +
					((r.func == gia_pkg::FN_ADD_CC) ? 33'd0 : {32'd0, carry_model});
				o.result = {32'd0, sum[gia_pkg::WORD_W-1:0]};
				if (r.func != gia_pkg::FN_ADDC)
					carry_model = sum[gia_pkg::WORD_W];
			end
			gia_pkg::FN_SUB_CC, gia_pkg::FN_SUBC_CC, gia_pkg::FN_SUBC: begin
				sum = {1'b0, r.a} + {1'b0, ~r.b} +
					((r.func == gia_pkg::FN_SUB_CC) ? 33'd1 : {32'd0, carry_model});
				o.result = {32'd0, sum[gia_pkg::WORD_W-1:0]};
				if (r.func != gia_pkg::FN_SUBC)
					carry_model = sum[gia_pkg::WORD_W];
			end
			gia_pkg::FN_FUNNELSHIFT: begin
				shifted = {r.b, r.a} << r.c[gia_pkg::SHAMT_W-1:0];
				o.result = {32'd0, shifted[2*gia_pkg::WORD_W-1:gia_pkg::WORD_W]};
			end
			gia_pkg::FN_PERMUTE: o.result = {32'd0, permute_bytes(r.a, r.b, r.c[15:0])};
			default: o.result = '0;
		endcase
		o.carry_out = carry_model;
		return o;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.func <= '0;
			req_ch.operand_a <= '0;
			req_ch.operand_b <= '0;
			req_ch.operand_c <= '0;
		end else if (!req_ch.valid || req_ch.ready) begin
			if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_op = pending_ops.pop_front();
				req_ch.valid <= 1'b1;
				req_ch.func <= next_op.func;
				req_ch.operand_a <= next_op.a;
				req_ch.operand_b <= next_op.b;
				req_ch.operand_c <= next_op.c;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// response ready, with a long hold-off when asked
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			hold_cnt <= 0;
		end else if (long_hold) begin
			if (hold_cnt < LONG_HOLD) begin
				rsp_ch.ready <= 1'b0;
				hold_cnt <= hold_cnt + 1;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end else begin
			hold_cnt <= 0;
			rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
		end
	end

	// monitor: check responses, then predict accepted requests
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_model = 1'b0;
			expected_rsps.delete();
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_rsps.size() == 0) begin
					$error("response with nothing expected: result %h carry_out %b",
						rsp_ch.result, rsp_ch.carry_out);
					err_cnt++;
				end else begin
					want = expected_rsps.pop_front();
					if (rsp_ch.result !== want.result) begin
						$error("result: expected %h, got %h", want.result, rsp_ch.result);
						err_cnt++;
					end
					if (rsp_ch.carry_out !== want.carry_out) begin
						$error("carry_out: expected %b, got %b", want.carry_out,
							rsp_ch.carry_out);
						err_cnt++;
					end
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				seen_op.func = req_ch.func;
				seen_op.a = req_ch.operand_a;
				seen_op.b = req_ch.operand_b;
				seen_op.c = req_ch.operand_c;
				expected_rsps.push_back(compute_alu_op(seen_op));
			end
		end
	end

	task automatic push_op(input logic [gia_pkg::FUNC_W-1:0] f,
		input logic [gia_pkg::WORD_W-1:0] a, input logic [gia_pkg::WORD_W-1:0] b,
		input logic [gia_pkg::WIDE_W-1:0] c);
		alu_req_t r;
		r.func = f;
		r.a = a;
		r.b = b;
		r.c = c;
		pending_ops.push_back(r);
	endtask

	function automatic logic [gia_pkg::WORD_W-1:0] pick_word();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4: return $urandom_range(15);
			default: return $urandom;
		endcase
	endfunction

	// mostly carry chains with random operands, the rest single random ops
	task automatic add_random_ops(input int n);
		int cnt;
		int len;
		int kind;
		logic [gia_pkg::FUNC_W-1:0] f;
		cnt = 0;
		while (cnt < n) begin
			if ($urandom_range(99) < 70) begin
				kind = $urandom_range(2);
				len = $urandom_range(4, 2);
				for (int i = 0; i < len; i++) begin
					case (kind)
						0: f = (i == 0) ? gia_pkg::FN_ADD_CC :
							(i == len - 1 && $urandom_range(1)) ? gia_pkg::FN_ADDC :
							gia_pkg::FN_ADDC_CC;
						1: f = (i == 0) ? gia_pkg::FN_SUB_CC :
							(i == len - 1 && $urandom_range(1)) ? gia_pkg::FN_SUBC :
							gia_pkg::FN_SUBC_CC;
						default: f = (i == 0 || $urandom_range(1)) ?
							gia_pkg::FN_MADWIDE_CC : gia_pkg::FN_MADWIDEC;
					endcase
					push_op(f, pick_word(), pick_word(), {pick_word(), pick_word()});
				end
				cnt += len;
			end else begin
				if ($urandom_range(9) == 0)
					f = gia_pkg::FUNC_W'($urandom_range(FN_UNUSED_HI, FN_UNUSED_LO));
				else
					f = gia_pkg::FUNC_W'($urandom_range(gia_pkg::FN_PERMUTE,
						gia_pkg::FN_MULWIDE));
				push_op(f, pick_word(), pick_word(), {pick_word(), pick_word()});
				cnt++;
			end
		end
	endtask

	task automatic wait_drained();
		while (pending_ops.size() != 0 || req_ch.valid || expected_rsps.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, every opcode, ignored bits, wraparound, unused opcodes
		push_op(gia_pkg::FN_MULWIDE, '1, '1, 64'h0123_4567_89AB_CDEF);
		push_op(gia_pkg::FN_MULWIDE, '0, '1, '1);
		push_op(gia_pkg::FN_MADWIDE_CC, '1, '1, '1);
		push_op(gia_pkg::FN_MADWIDEC, 32'd1, 32'd1, '1);
		push_op(gia_pkg::FN_MADWIDE_CC, '0, '0, '0);
		push_op(gia_pkg::FN_MADWIDEC, '1, '1, '0);
		push_op(gia_pkg::FN_ADD_CC, '1, 32'd1, '1);
		push_op(gia_pkg::FN_ADDC, '0, '0, '0);
		push_op(gia_pkg::FN_ADDC_CC, '1, '0, '1);
		push_op(gia_pkg::FN_ADD_CC, 32'h7FFF_FFFF, 32'd1, '0);
		push_op(gia_pkg::FN_ADDC_CC, '1, '1, '0);
		push_op(gia_pkg::FN_SUB_CC, '0, 32'd1, '1);
		push_op(gia_pkg::FN_SUBC, 32'd5, 32'd5, '0);
		push_op(gia_pkg::FN_SUBC_CC, 32'd5, 32'd5, '0);
		push_op(gia_pkg::FN_SUB_CC, 32'd5, 32'd5, '0);
		push_op(gia_pkg::FN_SUBC_CC, 32'h8000_0000, 32'h7FFF_FFFF, '1);
		push_op(gia_pkg::FN_FUNNELSHIFT, 32'h89AB_CDEF, 32'h0123_4567,
			64'hFFFF_FFFF_FFFF_FFE0);
		push_op(gia_pkg::FN_FUNNELSHIFT, 32'h89AB_CDEF, 32'h0123_4567, 64'd31);
		push_op(gia_pkg::FN_FUNNELSHIFT, '1, '0, 64'hFFFF_FFFF_FFFF_FFE1);
		push_op(gia_pkg::FN_PERMUTE, 32'h4433_2211, 32'h8877_6655, 64'h3210);
		push_op(gia_pkg::FN_PERMUTE, 32'h4433_2211, 32'h8877_6655,
			64'hFFFF_FFFF_FFFF_7654);
		push_op(gia_pkg::FN_PERMUTE, 32'h0080_0180, 32'h80FF_7F00, 64'hFEDC);
		push_op(gia_pkg::FN_PERMUTE, 32'h0080_0180, 32'h80FF_7F00,
			64'h0000_1234_0000_BA98);
		push_op(FN_UNUSED_LO, '1, '1, '1);
		push_op(FN_UNUSED_HI, '1, '1, '1);
		wait_drained();

		add_random_ops(250);
		wait_drained();

		send_idle_pct = 69;
		add_random_ops(230);
		wait_drained();

		send_idle_pct = 0;
		rsp_stall_pct = 69;
		add_random_ops(230);
		wait_drained();

		send_idle_pct = 30;
		rsp_stall_pct = 30;
		add_random_ops(230);
		wait_drained();

		// sink holds off while the source keeps offering
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		long_hold = 1'b1;
		add_random_ops(40);
		wait_drained();
		long_hold = 1'b0;

		repeat (10) @(negedge clk);
		if (err_cnt == 0 && expected_rsps.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#1000000;
		$display("simulation failed");
		$finish;
	end

endmodule
